### rtl/mlbc_pkg.sv
// package: command codes, per-led request struct and sizing constants for the led blink core
`default_nettype none
package mlbc_pkg;

  localparam int unsigned NumLedsDefault = 8;
  localparam int unsigned LineWidth      = 8;
  localparam int unsigned IndexWidth     = 3;
  localparam int unsigned CountWidth     = 8;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ENABLE    = 3'd1,
    CMD_ON        = 3'd2,
    CMD_OFF       = 3'd3,
    CMD_TOGGLE    = 3'd4,
    CMD_SET_STATE = 3'd5,
    CMD_SET_MODE  = 3'd6,
    CMD_SET_BLINK = 3'd7
  } cmd_e;

  // request seen by every led slice in the execute cycle
  typedef struct packed {
    logic                  tick;
    logic                  sel;
    cmd_e                  cmd;
    logic                  state_value;
    logic                  mode_value;
    logic [CountWidth-1:0] on_delay;
    logic [CountWidth-1:0] off_delay;
  } led_req_t;

endpackage
`default_nettype wire

### rtl/multi_led_blink_controller_core.sv
// top level: command register, bank of led slices and result register
`default_nettype none
// multi led blink controller core
//
// command channel: an item (command_i, led_index_i, state_value_i, mode_value_i,
// on_delay_i, off_delay_i) is taken at a rising edge with start high and busy low.
// busy stays low, so an item may be issued in every cycle.
//
// result channel: done_o is high for one cycle with led_lines_o and index_valid_o;
// the receiver takes it at the edge that ends that cycle and cannot hold it off.
//
// path: the item is registered at the accept edge, executed by all led slices
// in parallel in the next cycle and the result is registered at the following
// edge in the result register that drives done_o. throughput: one item
// per cycle, set by the single execute cycle that reads and writes the led state.
//
// reset (rst_ni low, asynchronous): all leds off, disabled, steady, counters and
// limits zero, no item in flight and no result shown.
module multi_led_blink_controller_core #(
  parameter int unsigned NUM_LEDS = mlbc_pkg::NumLedsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          command_i,
  input  logic [mlbc_pkg::IndexWidth-1:0]     led_index_i,
  input  logic                                state_value_i,
  input  logic                                mode_value_i,
  input  logic [mlbc_pkg::CountWidth-1:0]     on_delay_i,
  input  logic [mlbc_pkg::CountWidth-1:0]     off_delay_i,
  output logic                                done_o,
  output logic [mlbc_pkg::LineWidth-1:0]      led_lines_o,
  output logic                                index_valid_o
);
  import mlbc_pkg::*;

  // command register
  logic                  cmd_vld_q;
  cmd_e                  cmd_q;
  logic [IndexWidth-1:0] idx_q;
  logic                  sv_q;
  logic                  mv_q;
  logic [CountWidth-1:0] don_q;
  logic [CountWidth-1:0] doff_q;

  // result register
  logic                 done_q;
  logic [LineWidth-1:0] lines_q, lines_d;
  logic                 ivld_q, ivld_d;

  logic [NUM_LEDS-1:0] led_on_d;
  logic                idx_in_range;
  logic                is_tick;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= start && !busy;
    end
  end

  // payload is captured on accept only, no reset needed
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= led_index_i;
      sv_q   <= state_value_i;
      mv_q   <= mode_value_i;
      don_q  <= on_delay_i;
      doff_q <= off_delay_i;
    end
  end

  assign is_tick      = (cmd_q == CMD_TICK);
  // the index is only three bits, so a bank of eight or more always passes
  assign idx_in_range = (32'(idx_q) < NUM_LEDS);

  // one slice per led, all updated in the same cycle
  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    led_req_t req;
    logic     hit;
    if (i < (1 << IndexWidth)) begin : g_addr
      assign hit = (idx_q == IndexWidth'(i));
    end else begin : g_noaddr
      assign hit = 1'b0;   // beyond the index range, never addressed
    end
    assign req.tick        = cmd_vld_q && is_tick;
    assign req.sel         = cmd_vld_q && !is_tick && hit;
    assign req.cmd         = cmd_q;
    assign req.state_value = sv_q;
    assign req.mode_value  = mv_q;
    assign req.on_delay    = don_q;
    assign req.off_delay   = doff_q;

    mlbc_led_slice u_slice (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (req),
      .led_on_d_o (led_on_d[i])
    );
  end

  // drive lines after this item; only the first eight leds are visible
  for (genvar b = 0; b < LineWidth; b++) begin : g_line
    if (b < NUM_LEDS) begin : g_used
      assign lines_d[b] = led_on_d[b];
    end else begin : g_unused
      assign lines_d[b] = 1'b0;
    end
  end

  assign ivld_d = is_tick || idx_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_q) begin
      lines_q <= lines_d;
      ivld_q  <= ivld_d;
    end
  end

  assign done_o        = done_q;
  assign led_lines_o   = lines_q;
  assign index_valid_o = ivld_q;

endmodule
`default_nettype wire

### rtl/mlbc_led_slice.sv
// one led: state, blink counters and limits, updated by the current request
`default_nettype none
module mlbc_led_slice (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlbc_pkg::led_req_t req_i,
  output logic              led_on_d_o
);
  import mlbc_pkg::*;

  logic                  on_q, on_d;
  logic                  en_q, en_d;
  logic                  blink_q, blink_d;
  logic [CountWidth-1:0] on_cnt_q, on_cnt_d;
  logic [CountWidth-1:0] off_cnt_q, off_cnt_d;
  logic [CountWidth-1:0] on_lim_q, on_lim_d;
  logic [CountWidth-1:0] off_lim_q, off_lim_d;

  always_comb begin
    on_d      = on_q;
    en_d      = en_q;
    blink_d   = blink_q;
    on_cnt_d  = on_cnt_q;
    off_cnt_d = off_cnt_q;
    on_lim_d  = on_lim_q;
    off_lim_d = off_lim_q;
    if (req_i.tick) begin
      if (en_q && blink_q) begin
        // on phase: compare old count, then count
        if (on_q) begin
          on_cnt_d = on_cnt_q + 1'b1;
          if (on_cnt_q > on_lim_q) begin
            on_d     = 1'b0;
            on_cnt_d = '0;
          end
        end
        // off phase, also for an led that just went off
        if (!on_d) begin
          off_cnt_d = off_cnt_q + 1'b1;
          if (off_cnt_q > off_lim_q) begin
            on_d      = 1'b1;
            off_cnt_d = '0;
          end
        end
      end
    end else if (req_i.sel) begin
      case (req_i.cmd)
        CMD_ENABLE: begin
          en_d      = 1'b1;
          on_d      = 1'b0;
          blink_d   = 1'b0;
          on_cnt_d  = '0;
          off_cnt_d = '0;
          on_lim_d  = '0;
          off_lim_d = '0;
        end
        CMD_ON:        on_d = 1'b1;
        CMD_OFF:       on_d = 1'b0;
        CMD_TOGGLE:    on_d = ~on_q;
        CMD_SET_STATE: on_d = req_i.state_value;
        CMD_SET_MODE:  blink_d = req_i.mode_value;
        CMD_SET_BLINK: begin
          blink_d   = 1'b1;
          on_lim_d  = req_i.on_delay;
          off_lim_d = req_i.off_delay;
          on_cnt_d  = '0;
          off_cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      en_q      <= 1'b0;
      blink_q   <= 1'b0;
      on_cnt_q  <= '0;
      off_cnt_q <= '0;
      on_lim_q  <= '0;
      off_lim_q <= '0;
    end else begin
      on_q      <= on_d;
      en_q      <= en_d;
      blink_q   <= blink_d;
      on_cnt_q  <= on_cnt_d;
      off_cnt_q <= off_cnt_d;
      on_lim_q  <= on_lim_d;
      off_lim_q <= off_lim_d;
    end
  end

  assign led_on_d_o = on_d;

endmodule
`default_nettype wire

### rtl/mlbc_checker.sv
// port-level checker for the led blink core and its bind
`default_nettype none
module mlbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [2:0]                      command_i,
  input logic                            done_o,
  input logic                            index_valid_o
);
  import mlbc_pkg::*;

  // every accepted item gives a result on done_o
  a_item_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted item gave no result");

  // no result without an accepted item before it
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an item");

  // a tick always reports a usable index
  a_tick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(command_i, 2) == CMD_TICK) |-> index_valid_o)
    else $error("tick result flagged invalid");

  // results never come in a burst longer than the items accepted
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(start, 2)) |-> 1'b0)
    else $error("extra result");

endmodule

bind multi_led_blink_controller_core mlbc_checker u_mlbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .done_o        (done_o),
  .index_valid_o (index_valid_o)
);
`default_nettype wire
